// File: hw/rtl/smx_pkg.sv
// Shared types and constants of the stack machine execute unit.
// Depends on nothing; every other file uses it.
package smx_pkg;

  localparam int STACK_DEPTH = 16384;
  localparam int CODE_DEPTH  = 65536;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int SP_W        = $clog2(STACK_DEPTH + 3);
  localparam int PC_W        = $clog2(CODE_DEPTH);
  localparam int WORD_W      = 32;
  localparam int OUT_PC_W    = 16;

  typedef enum logic [7:0] {
    OP_NOP  = 8'd0,  OP_HALT = 8'd1,  OP_ADD = 8'd2,  OP_LD  = 8'd3,
    OP_BR   = 8'd4,  OP_SUB  = 8'd5,  OP_MUL = 8'd6,  OP_DIV = 8'd7,
    OP_AND  = 8'd8,  OP_OR   = 8'd9,  OP_EQ  = 8'd10, OP_GT  = 8'd11,
    OP_NOT  = 8'd12, OP_BRF  = 8'd13, OP_CAL = 8'd14, OP_RET = 8'd15,
    OP_LOC  = 8'd16, OP_STV  = 8'd17, OP_LDA = 8'd18, OP_LDV = 8'd19,
    OP_WR   = 8'd20, OP_RD   = 8'd21
  } opcode_e;

  typedef enum logic [1:0] {
    STAT_RUN   = 2'd0,
    STAT_HALT  = 2'd1,
    STAT_BADOP = 2'd2,
    STAT_FAULT = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_RDA, S_RDB, S_GOTB, S_ALU, S_DIV, S_GOTA,
    S_LDVR, S_LDVG, S_WALK, S_WALKR, S_CAL0, S_CAL1, S_CAL2,
    S_RET1, S_RET2, S_RET3, S_LOC, S_PUSH, S_FIN
  } state_e;

  typedef struct packed {
    logic              en;
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] wdata;
  } mem_req_t;

  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] dividend;
    logic [WORD_W-1:0] divisor;
  } div_req_t;

endpackage

// File: hw/rtl/smx_if.sv
// Valid/ready channel interfaces for instruction words and result words.
// Depends on smx_pkg for field widths.
interface smx_in_if;
  import smx_pkg::*;
  logic              valid;
  logic              ready;
  logic [7:0]        opcode;
  logic [WORD_W-1:0] operand_word;
  logic [WORD_W-1:0] read_value;
  modport source (output valid, opcode, operand_word, read_value, input ready);
  modport sink   (input valid, opcode, operand_word, read_value, output ready);
endinterface

interface smx_out_if;
  import smx_pkg::*;
  logic                valid;
  logic                ready;
  logic [OUT_PC_W-1:0] next_pc;
  logic                write_valid;
  logic [WORD_W-1:0]   write_value;
  logic [1:0]          status;
  modport source (output valid, next_pc, write_valid, write_value, status, input ready);
  modport sink   (input valid, next_pc, write_valid, write_value, status, output ready);
endinterface

// File: hw/rtl/stack_machine_execute_unit.sv
// Executes one instruction word per accepted input and returns one result word. Simple
// instructions (nop, halt, br) need no stack access; stack ops are paced by the single
// port of the stack RAM (one read or write per cycle, registered read data); div waits
// in the bit-serial divider in place of the ALU state; every static link followed takes
// a read state and a pointer-update state; loc writes one cleared word per loc step.
// A new word is accepted while a result still waits.
// Depends on smx_pkg, smx_if, smx_stack_ram and smx_div.
module stack_machine_execute_unit (
  input  logic clk_i,
  input  logic rst_ni,
  smx_in_if.sink    in_i,
  smx_out_if.source out_o
);
  import smx_pkg::*;

  localparam logic [WORD_W-1:0] DEPTH_W  = WORD_W'(STACK_DEPTH);
  localparam logic [WORD_W-1:0] DEPTH_W2 = WORD_W'(STACK_DEPTH + 2);
  localparam logic [SP_W-1:0]   DEPTH_SP = SP_W'(STACK_DEPTH);

  state_e               state_q, state_d;
  logic [SP_W-1:0]      sp_q, sp_d, fp_q, fp_d, cnt_q, cnt_d;
  logic [PC_W-1:0]      pc_q, pc_d, next_q, next_d;
  logic                 stopped_q, stopped_d, fault_q, fault_d, wv_q, wv_d, fwd_q, fwd_d;
  status_e              stop_code_q, stop_code_d, code_q, code_d;
  logic [7:0]           op_q, op_d;
  logic [WORD_W-1:0]    w_q, w_d, rv_q, rv_d, a_q, a_d, b_q, b_d, r_q, r_d, ptr_q, ptr_d;
  logic [ADDR_W-1:0]    waddr_q, waddr_d;
  logic                 ov_q, ov_d, owv_q, owv_d;
  logic [OUT_PC_W-1:0]  onpc_q, onpc_d;
  logic [WORD_W-1:0]    owval_q, owval_d;
  logic [1:0]           ost_q, ost_d;

  mem_req_t             mem_req;
  logic [WORD_W-1:0]    mem_rdata;
  div_req_t             div_req;
  logic                 div_done;
  logic [WORD_W-1:0]    div_quot;

  logic [PC_W-1:0]      np1, np2;
  logic [SP_W-1:0]      avail;
  logic                 out_free, is_bin;
  logic [WORD_W:0]      ret_sum;

  smx_stack_ram #(.DEPTH(STACK_DEPTH), .WIDTH(WORD_W)) u_ram (
    .clk_i  (clk_i),
    .req_i  (mem_req),
    .rdata_o(mem_rdata)
  );

  smx_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .done_o(div_done),
    .quot_o(div_quot)
  );

  assign np1      = pc_q + PC_W'(1);
  assign np2      = pc_q + PC_W'(2);
  assign avail    = DEPTH_SP - sp_q;
  assign out_free = !ov_q || out_o.ready;
  assign is_bin   = op_q inside {OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_AND, OP_OR, OP_EQ, OP_GT};
  assign ret_sum  = (WORD_W+1)'(fp_q) + {1'b0, w_q};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_i.valid) state_d = S_DECODE;
      S_DECODE: begin
        if (stopped_q) begin
          state_d = S_FIN;
        end else begin
          case (opcode_e'(op_q))
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_AND, OP_OR, OP_EQ, OP_GT, OP_STV, OP_LDA:
              state_d = (avail < SP_W'(2)) ? S_FIN : S_RDA;
            OP_NOT, OP_BRF, OP_WR, OP_LDV, OP_RET:
              state_d = (avail < SP_W'(1) ||
                         (opcode_e'(op_q) == OP_RET &&
                          (fp_q < SP_W'(2) || fp_q >= DEPTH_SP))) ? S_FIN : S_RDA;
            OP_CAL:   state_d = (avail < SP_W'(1) || sp_q < SP_W'(2)) ? S_FIN : S_RDA;
            OP_LD, OP_RD: state_d = (sp_q == '0) ? S_FIN : S_PUSH;
            OP_LOC:   state_d = (w_q > WORD_W'(sp_q)) ? S_FIN : S_LOC;
            default:  state_d = S_FIN;
          endcase
        end
      end
      S_RDA: begin
        if (is_bin || op_q == OP_STV || op_q == OP_LDA) state_d = S_RDB;
        else if (op_q == OP_RET) state_d = S_RET1;
        else state_d = S_GOTA;
      end
      S_RDB: state_d = S_GOTB;
      S_GOTB: begin
        case (opcode_e'(op_q))
          OP_DIV:  state_d = S_DIV;
          OP_STV:  state_d = (a_q >= DEPTH_W) ? S_FIN : S_PUSH;
          OP_LDA:  state_d = (mem_rdata > DEPTH_W) ? S_FIN : S_WALK;
          default: state_d = S_ALU;
        endcase
      end
      S_ALU: state_d = S_PUSH;
      S_DIV: if (div_done) state_d = S_PUSH;
      S_GOTA: begin
        case (opcode_e'(op_q))
          OP_NOT:  state_d = S_PUSH;
          OP_LDV:  state_d = (mem_rdata >= DEPTH_W) ? S_FIN : S_LDVR;
          OP_CAL: begin
            if (mem_rdata == '1) state_d = S_CAL0;
            else if (mem_rdata > DEPTH_W) state_d = S_FIN;
            else state_d = S_WALK;
          end
          default: state_d = S_FIN;
        endcase
      end
      S_LDVR: state_d = S_LDVG;
      S_LDVG: state_d = S_PUSH;
      S_WALK: begin
        if (cnt_q == '0) state_d = (op_q == OP_CAL) ? S_CAL0 : S_PUSH;
        else if (ptr_q == '0 || ptr_q > DEPTH_W) state_d = S_FIN;
        else state_d = S_WALKR;
      end
      S_WALKR: state_d = S_WALK;
      S_CAL0:  state_d = S_CAL1;
      S_CAL1:  state_d = S_CAL2;
      S_CAL2:  state_d = S_FIN;
      S_RET1:  state_d = S_RET2;
      S_RET2:  state_d = S_RET3;
      S_RET3: begin
        if (ret_sum >= (WORD_W+1)'(STACK_DEPTH) || b_q > DEPTH_W2) state_d = S_FIN;
        else state_d = S_PUSH;
      end
      S_LOC:  if (cnt_q == '0) state_d = S_FIN;
      S_PUSH: state_d = S_FIN;
      S_FIN:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // memory, divider and handshake outputs
  always_comb begin
    mem_req          = '0;
    div_req.start    = (state_q == S_GOTB) && (op_q == OP_DIV);
    div_req.dividend = a_q;
    div_req.divisor  = mem_rdata;
    in_i.ready       = (state_q == S_IDLE);
    case (state_q)
      S_RDA: begin
        mem_req.en   = 1'b1;
        mem_req.addr = sp_q[ADDR_W-1:0];
      end
      S_RDB: begin
        mem_req.en   = 1'b1;
        mem_req.addr = ADDR_W'(sp_q + SP_W'(1));
      end
      S_LDVR: begin
        mem_req.en   = 1'b1;
        mem_req.addr = a_q[ADDR_W-1:0];
      end
      S_WALK: begin
        mem_req.en   = (cnt_q != '0) && (ptr_q != '0) && (ptr_q <= DEPTH_W);
        mem_req.addr = ADDR_W'(ptr_q - WORD_W'(1));
      end
      S_RET1: begin
        mem_req.en   = 1'b1;
        mem_req.addr = fp_q[ADDR_W-1:0];
      end
      S_RET2: begin
        mem_req.en   = 1'b1;
        mem_req.addr = ADDR_W'(fp_q - SP_W'(2));
      end
      S_CAL0: begin
        mem_req.en    = 1'b1;
        mem_req.we    = 1'b1;
        mem_req.addr  = sp_q[ADDR_W-1:0];
        mem_req.wdata = WORD_W'(fp_q);
      end
      S_CAL1: begin
        mem_req.en    = 1'b1;
        mem_req.we    = 1'b1;
        mem_req.addr  = ADDR_W'(sp_q - SP_W'(1));
        mem_req.wdata = ptr_q;
      end
      S_CAL2: begin
        mem_req.en    = 1'b1;
        mem_req.we    = 1'b1;
        mem_req.addr  = ADDR_W'(sp_q - SP_W'(2));
        mem_req.wdata = WORD_W'(np2);
      end
      S_LOC: begin
        mem_req.en    = (cnt_q != '0);
        mem_req.we    = 1'b1;
        mem_req.addr  = ADDR_W'(sp_q - SP_W'(1));
      end
      S_PUSH: begin
        mem_req.en    = 1'b1;
        mem_req.we    = 1'b1;
        mem_req.addr  = waddr_q;
        mem_req.wdata = r_q;
      end
      default: ;
    endcase
  end

  // datapath
  always_comb begin
    sp_d = sp_q; fp_d = fp_q; pc_d = pc_q; cnt_d = cnt_q; next_d = next_q;
    stopped_d = stopped_q; stop_code_d = stop_code_q; fault_d = fault_q;
    code_d = code_q; wv_d = wv_q; fwd_d = fwd_q;
    op_d = op_q; w_d = w_q; rv_d = rv_q; a_d = a_q; b_d = b_q; r_d = r_q;
    ptr_d = ptr_q; waddr_d = waddr_q;
    ov_d = ov_q && !out_o.ready;
    onpc_d = onpc_q; owv_d = owv_q; owval_d = owval_q; ost_d = ost_q;
    case (state_q)
      S_IDLE: begin
        op_d = in_i.opcode; w_d = in_i.operand_word; rv_d = in_i.read_value;
      end
      S_DECODE: begin
        fault_d = 1'b0; wv_d = 1'b0; code_d = STAT_RUN; next_d = np1;
        if (stopped_q) begin
          next_d = pc_q;
          code_d = stop_code_q;
        end else begin
          case (opcode_e'(op_q))
            OP_NOP: ;
            OP_HALT: code_d = STAT_HALT;
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_AND, OP_OR, OP_EQ, OP_GT, OP_STV, OP_LDA:
              fault_d = (avail < SP_W'(2));
            OP_NOT, OP_BRF, OP_WR, OP_LDV:
              fault_d = (avail < SP_W'(1));
            OP_RET: fault_d = avail < SP_W'(1) || fp_q < SP_W'(2) || fp_q >= DEPTH_SP;
            OP_CAL: fault_d = avail < SP_W'(1) || sp_q < SP_W'(2);
            OP_BR:  next_d = w_q[PC_W-1:0];
            OP_LD, OP_RD: begin
              fault_d = (sp_q == '0);
              r_d     = (op_q == OP_LD) ? w_q : rv_q;
              waddr_d = ADDR_W'(sp_q - SP_W'(1));
              sp_d    = (sp_q == '0) ? sp_q : sp_q - SP_W'(1);
              if (op_q == OP_LD) next_d = np2;
            end
            OP_LOC: begin
              fault_d = (w_q > WORD_W'(sp_q));
              if (w_q <= WORD_W'(sp_q)) begin
                fp_d  = sp_q + SP_W'(2);
                cnt_d = w_q[SP_W-1:0];
              end
              next_d = np2;
            end
            default: code_d = STAT_BADOP;
          endcase
        end
      end
      S_RDB: a_d = mem_rdata;
      S_GOTB: begin
        b_d = mem_rdata;
        case (opcode_e'(op_q))
          OP_STV: begin
            if (a_q >= DEPTH_W) begin
              fault_d = 1'b1;
            end else begin
              sp_d = sp_q + SP_W'(2); waddr_d = a_q[ADDR_W-1:0]; r_d = mem_rdata;
            end
          end
          OP_LDA: begin
            if (mem_rdata > DEPTH_W) fault_d = 1'b1;
            cnt_d = mem_rdata[SP_W-1:0];
            ptr_d = WORD_W'(fp_q);
          end
          default: ;
        endcase
      end
      S_ALU: begin
        case (opcode_e'(op_q))
          OP_ADD:  r_d = a_q + b_q;
          OP_SUB:  r_d = a_q - b_q;
          OP_MUL:  r_d = a_q * b_q;
          OP_AND:  r_d = WORD_W'(a_q != '0 && b_q != '0);
          OP_OR:   r_d = WORD_W'(a_q != '0 || b_q != '0);
          OP_EQ:   r_d = WORD_W'(a_q == b_q);
          default: r_d = WORD_W'(a_q >= b_q);
        endcase
        waddr_d = ADDR_W'(sp_q + SP_W'(1));
        sp_d    = sp_q + SP_W'(1);
      end
      S_DIV: begin
        if (div_done) begin
          r_d     = div_quot;
          waddr_d = ADDR_W'(sp_q + SP_W'(1));
          sp_d    = sp_q + SP_W'(1);
        end
      end
      S_GOTA: begin
        a_d = mem_rdata;
        case (opcode_e'(op_q))
          OP_NOT: begin
            r_d = WORD_W'(mem_rdata == '0); waddr_d = sp_q[ADDR_W-1:0];
          end
          OP_BRF: begin
            sp_d   = sp_q + SP_W'(1);
            next_d = (mem_rdata == '0) ? w_q[PC_W-1:0] : np2;
          end
          OP_WR: begin
            sp_d = sp_q + SP_W'(1); wv_d = 1'b1;
          end
          OP_LDV: fault_d = (mem_rdata >= DEPTH_W);
          OP_CAL: begin
            ptr_d = WORD_W'(fp_q);
            if (mem_rdata != '1) begin
              fault_d = (mem_rdata > DEPTH_W);
              cnt_d   = SP_W'(mem_rdata) + SP_W'(1);
            end
          end
          default: ;
        endcase
      end
      S_LDVG: begin
        r_d = mem_rdata; waddr_d = sp_q[ADDR_W-1:0];
      end
      S_WALK: begin
        if (cnt_q == '0) begin
          if (op_q == OP_LDA) begin
            r_d     = ptr_q - a_q;
            waddr_d = ADDR_W'(sp_q + SP_W'(1));
            sp_d    = sp_q + SP_W'(1);
          end
        end else if (ptr_q == '0 || ptr_q > DEPTH_W) begin
          fault_d = 1'b1;
        end else begin
          // during a call the entry at the top is not yet written with the frame pointer, so fp_q is forwarded
          fwd_d = (op_q == OP_CAL) && (ptr_q == WORD_W'(sp_q) + WORD_W'(1));
        end
      end
      S_WALKR: begin
        ptr_d = fwd_q ? WORD_W'(fp_q) : mem_rdata;
        cnt_d = cnt_q - SP_W'(1);
      end
      S_CAL2: begin
        sp_d = sp_q - SP_W'(2); next_d = w_q[PC_W-1:0];
      end
      S_RET1: a_d = mem_rdata;
      S_RET2: b_d = mem_rdata;
      S_RET3: begin
        if (ret_sum >= (WORD_W+1)'(STACK_DEPTH) || b_q > DEPTH_W2) begin
          fault_d = 1'b1;
        end else begin
          fp_d    = b_q[SP_W-1:0];
          sp_d    = ret_sum[SP_W-1:0];
          waddr_d = ret_sum[ADDR_W-1:0];
          r_d     = a_q;
          next_d  = mem_rdata[PC_W-1:0];
        end
      end
      S_LOC: begin
        if (cnt_q != '0) begin
          sp_d = sp_q - SP_W'(1); cnt_d = cnt_q - SP_W'(1);
        end
      end
      S_FIN: begin
        if (out_free) begin
          ov_d = 1'b1;
          if (fault_q) begin
            onpc_d = OUT_PC_W'(pc_q); owv_d = 1'b0; owval_d = '0; ost_d = STAT_FAULT;
            stopped_d = 1'b1; stop_code_d = STAT_FAULT;
          end else begin
            onpc_d  = OUT_PC_W'(next_q);
            owv_d   = wv_q;
            owval_d = wv_q ? a_q : '0;
            ost_d   = code_q;
            pc_d    = next_q;
            if (code_q != STAT_RUN) begin
              stopped_d = 1'b1; stop_code_d = code_q;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sp_q        <= DEPTH_SP;
      fp_q        <= DEPTH_SP - SP_W'(1);
      pc_q        <= '0;
      stopped_q   <= 1'b0;
      stop_code_q <= STAT_RUN;
      ov_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      sp_q        <= sp_d;
      fp_q        <= fp_d;
      pc_q        <= pc_d;
      stopped_q   <= stopped_d;
      stop_code_q <= stop_code_d;
      ov_q        <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d; next_q <= next_d; fault_q <= fault_d; code_q <= code_d;
    wv_q <= wv_d; fwd_q <= fwd_d; op_q <= op_d; w_q <= w_d; rv_q <= rv_d;
    a_q <= a_d; b_q <= b_d; r_q <= r_d; ptr_q <= ptr_d; waddr_q <= waddr_d;
    onpc_q <= onpc_d; owv_q <= owv_d; owval_q <= owval_d; ost_q <= ost_d;
  end

  assign out_o.valid       = ov_q;
  assign out_o.next_pc     = onpc_q;
  assign out_o.write_valid = owv_q;
  assign out_o.write_value = owval_q;
  assign out_o.status      = ost_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) sp_q <= DEPTH_SP)
    else $error("stack pointer beyond stack");
  assert property (@(posedge clk_i) disable iff (!rst_ni) stopped_q |=> stopped_q)
    else $error("unit restarted after stop");
  assert property (@(posedge clk_i) disable iff (!rst_ni) stopped_q |-> stop_code_q != STAT_RUN)
    else $error("stopped with running status");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == S_IDLE || state_q == S_FIN) |-> !mem_req.en)
    else $error("stack access outside an instruction");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (ov_q && !out_o.ready) |=> ov_q)
    else $error("result word dropped");
endmodule

// File: hw/rtl/smx_stack_ram.sv
// Single-port synchronous RAM for the data stack, with registered read data.
// Depends on smx_pkg for the request struct.
module smx_stack_ram #(
  parameter int DEPTH = 16384,
  parameter int WIDTH = 32
) (
  input  logic                  clk_i,
  input  smx_pkg::mem_req_t     req_i,
  output logic [WIDTH-1:0]      rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      if (req_i.we) begin
        mem[req_i.addr] <= req_i.wdata;
      end else begin
        rdata_o <= mem[req_i.addr];
      end
    end
  end
endmodule

// File: hw/rtl/smx_div.sv
// Restoring divider, one quotient bit per cycle; zero divisor yields all ones.
// Depends on smx_pkg for widths and the request struct.
module smx_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  smx_pkg::div_req_t         req_i,
  output logic                      done_o,
  output logic [smx_pkg::WORD_W-1:0] quot_o
);
  import smx_pkg::*;

  localparam int CNT_W = $clog2(WORD_W + 1);

  logic              busy_q, busy_d, done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [WORD_W-1:0] rem_q, rem_d;
  logic [WORD_W-1:0] quo_q, quo_d, dvs_q, dvs_d;
  logic [WORD_W:0]   rem_sh;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    rem_sh = {rem_q, quo_q[WORD_W-1]};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(WORD_W);
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, dvs_q}) begin
        rem_d = WORD_W'(rem_sh - {1'b0, dvs_q});
        quo_d = {quo_q[WORD_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[WORD_W-1:0];
        quo_d = {quo_q[WORD_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
endmodule

// File: tb/smx_tb_pkg.sv
`timescale 1ns / 1ps
// Result record shared by the execute-unit testbench.
// Depends on smx_pkg for widths.
package smx_tb_pkg;
  import smx_pkg::*;

  typedef struct packed {
    logic [OUT_PC_W-1:0] next_pc;
    logic                write_valid;
    logic [WORD_W-1:0]   write_value;
    logic [1:0]          status;
  } exec_result_t;

endpackage

// File: tb/tb.sv
`timescale 1ns / 1ps
// Top-level testbench of stack_machine_execute_unit: drives instruction words with random gaps,
// predicts each result word from a local machine model and checks it field by field.
// Depends on smx_pkg, smx_tb_pkg, smx_if and the RTL.
module tb;
  import smx_pkg::*;
  import smx_tb_pkg::*;

  localparam int unsigned DEPTH = STACK_DEPTH;
  localparam int unsigned IDLE_LIMIT = 200000;

  logic clk_i;
  logic rst_ni;

  smx_in_if  in_if ();
  smx_out_if out_if ();

  stack_machine_execute_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  logic [WORD_W-1:0] stk [DEPTH];
  bit                stk_ok [DEPTH];
  int unsigned       sp_q, fp_q, pc_q;
  bit                halted;
  logic [1:0]        halt_code;
  bit                bad_read;
  int unsigned       undo_addr [$];
  logic [WORD_W-1:0] undo_val [$];
  bit                undo_ok [$];

  exec_result_t pending_q [$];
  int unsigned  fail_cnt;
  int unsigned  idle_cnt;

  function automatic logic [WORD_W-1:0] peek(int unsigned a);
    if (a >= DEPTH || !stk_ok[a]) begin
      bad_read = 1'b1;
      return '0;
    end
    return stk[a];
  endfunction

  function automatic void poke(int unsigned a, logic [WORD_W-1:0] v);
    undo_addr.push_back(a);
    undo_val.push_back(stk[a]);
    undo_ok.push_back(stk_ok[a]);
    stk[a] = v;
    stk_ok[a] = 1'b1;
  endfunction

  function automatic bit walk_links(int unsigned start, int unsigned cnt,
                                    output int unsigned res);
    int unsigned p;
    p = start;
    res = 0;
    if (cnt > DEPTH) return 1'b0;
    while (cnt > 0) begin
      if (p == 0 || p - 1 >= DEPTH) return 1'b0;
      p = peek(p - 1);
      cnt--;
    end
    res = p;
    return 1'b1;
  endfunction

  function automatic exec_result_t exec_word(logic [7:0] op, logic [31:0] w,
                                             logic [31:0] rv);
    int unsigned sp, avail, nxt, np1, np2, a, b, r, t, saved, sl, dl, ra, res, cnt;
    longint unsigned nsp;
    bit flt;
    logic [1:0] code;
    bit wv;
    logic [31:0] wval;
    exec_result_t e;
    if (halted) begin
      e = '{next_pc: pc_q[15:0], write_valid: 1'b0, write_value: '0, status: halt_code};
      return e;
    end
    sp = sp_q;
    avail = DEPTH - sp;
    np1 = (pc_q + 1) % CODE_DEPTH;
    np2 = (pc_q + 2) % CODE_DEPTH;
    nxt = np1;
    code = STAT_RUN;
    wv = 1'b0;
    wval = '0;
    flt = 1'b0;
    case (op)
      OP_NOP: ;
      OP_HALT: code = STAT_HALT;
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_AND, OP_OR, OP_EQ, OP_GT: begin
        if (avail < 2) flt = 1'b1;
        else begin
          a = peek(sp);
          b = peek(sp + 1);
          case (op)
            OP_ADD: r = a + b;
            OP_SUB: r = a - b;
            OP_MUL: r = a * b;
            OP_DIV: r = (b == 0) ? 32'hFFFF_FFFF : a / b;
            OP_AND: r = (a != 0 && b != 0) ? 1 : 0;
            OP_OR:  r = (a != 0 || b != 0) ? 1 : 0;
            OP_EQ:  r = (a == b) ? 1 : 0;
            default: r = (a >= b) ? 1 : 0;
          endcase
          sp++;
          poke(sp, r);
        end
      end
      OP_LD: begin
        if (sp < 1) flt = 1'b1;
        else begin
          sp--;
          poke(sp, w);
          nxt = np2;
        end
      end
      OP_BR: nxt = w % CODE_DEPTH;
      OP_NOT: begin
        if (avail < 1) flt = 1'b1;
        else poke(sp, (peek(sp) == 0) ? 1 : 0);
      end
      OP_BRF: begin
        if (avail < 1) flt = 1'b1;
        else begin
          a = peek(sp);
          sp++;
          nxt = (a == 0) ? (w % CODE_DEPTH) : np2;
        end
      end
      OP_CAL: begin
        if (avail < 1 || sp < 2) flt = 1'b1;
        else begin
          a = peek(sp);
          saved = a;
          poke(sp, fp_q);
          if (a == 32'hFFFF_FFFF) sl = fp_q;
          else if (!walk_links(fp_q, a, t) || t == 0 || t - 1 >= DEPTH) begin
            poke(sp, saved);
            flt = 1'b1;
          end else sl = peek(t - 1);
          if (!flt) begin
            poke(sp - 1, sl);
            poke(sp - 2, np2);
            sp -= 2;
            nxt = w % CODE_DEPTH;
          end
        end
      end
      OP_RET: begin
        if (avail < 1 || fp_q < 2 || fp_q >= DEPTH) flt = 1'b1;
        else begin
          res = peek(sp);
          nsp = longint'(fp_q) + longint'(w) + 1;
          dl = peek(fp_q);
          ra = peek(fp_q - 2);
          if (nsp > DEPTH || dl > DEPTH + 2) flt = 1'b1;
          else begin
            fp_q = dl;
            sp = int'(nsp) - 1;
            poke(sp, res);
            nxt = ra % CODE_DEPTH;
          end
        end
      end
      OP_LOC: begin
        if (w > sp) flt = 1'b1;
        else begin
          fp_q = sp + 2;
          cnt = w;
          while (cnt > 0) begin
            sp--;
            poke(sp, '0);
            cnt--;
          end
          nxt = np2;
        end
      end
      OP_STV: begin
        if (avail < 2) flt = 1'b1;
        else begin
          a = peek(sp);
          b = peek(sp + 1);
          if (a >= DEPTH) flt = 1'b1;
          else begin
            sp += 2;
            poke(a, b);
          end
        end
      end
      OP_LDA: begin
        if (avail < 2) flt = 1'b1;
        else begin
          a = peek(sp);
          b = peek(sp + 1);
          if (!walk_links(fp_q, b, t)) flt = 1'b1;
          else begin
            sp++;
            poke(sp, t - a);
          end
        end
      end
      OP_LDV: begin
        if (avail < 1) flt = 1'b1;
        else begin
          a = peek(sp);
          if (a >= DEPTH) flt = 1'b1;
          else poke(sp, peek(a));
        end
      end
      OP_WR: begin
        if (avail < 1) flt = 1'b1;
        else begin
          wv = 1'b1;
          wval = peek(sp);
          sp++;
        end
      end
      OP_RD: begin
        if (sp < 1) flt = 1'b1;
        else begin
          sp--;
          poke(sp, rv);
        end
      end
      default: code = STAT_BADOP;
    endcase
    if (flt) begin
      halted = 1'b1;
      halt_code = STAT_FAULT;
      code = STAT_FAULT;
      nxt = pc_q;
      wv = 1'b0;
      wval = '0;
    end else begin
      sp_q = sp;
      pc_q = nxt;
      if (code != STAT_RUN) begin
        halted = 1'b1;
        halt_code = code;
      end
    end
    e = '{next_pc: nxt[15:0], write_valid: wv, write_value: wval, status: code};
    return e;
  endfunction

  // Apply the word to the model; roll it back if it reads an unwritten entry
  // or stops the machine when that is not wanted.
  function automatic bit try_word(logic [7:0] op, logic [31:0] w, logic [31:0] rv,
                                  bit allow_stop, output exec_result_t e);
    int unsigned s_sp, s_fp, s_pc;
    bit s_halted;
    logic [1:0] s_code;
    s_sp = sp_q;
    s_fp = fp_q;
    s_pc = pc_q;
    s_halted = halted;
    s_code = halt_code;
    undo_addr.delete();
    undo_val.delete();
    undo_ok.delete();
    bad_read = 1'b0;
    e = exec_word(op, w, rv);
    if (bad_read || (!allow_stop && e.status != STAT_RUN)) begin
      while (undo_addr.size() > 0) begin
        stk[undo_addr[$]] = undo_val.pop_back();
        stk_ok[undo_addr.pop_back()] = undo_ok.pop_back();
      end
      sp_q = s_sp;
      fp_q = s_fp;
      pc_q = s_pc;
      halted = s_halted;
      halt_code = s_code;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic send_word(logic [7:0] op, logic [31:0] w, logic [31:0] rv,
                           bit allow_stop, output bit sent);
    exec_result_t e;
    int unsigned gap;
    sent = try_word(op, w, rv, allow_stop, e);
    if (!sent) return;
    gap = $urandom_range(0, 4);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.opcode       <= op;
    in_if.operand_word <= w;
    in_if.read_value   <= rv;
    do @(posedge clk_i); while (!in_if.ready);
    pending_q.push_back(e);
  endtask

  task automatic issue(logic [7:0] op, logic [31:0] w = '0, logic [31:0] rv = '0);
    bit sent;
    send_word(op, w, rv, 1'b0, sent);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (pending_q.size() > 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom_range(0, 3);
      4: return 32'hFFFF_FFFF;
      5, 6: return $urandom;
      7, 8: return (sp_q < DEPTH) ? sp_q + $urandom_range(0, DEPTH - 1 - sp_q) : $urandom;
      default: return 32'h1 << $urandom_range(0, 31);
    endcase
  endfunction

  task automatic test_arith();
    issue(OP_LD, 0);
    issue(OP_LD, 7);
    issue(OP_DIV);
    issue(OP_WR);
    issue(OP_LD, 32'hFFFF_FFFF);
    issue(OP_LD, 3);
    issue(OP_MUL);
    issue(OP_LD, 2);
    issue(OP_SUB);
    issue(OP_ADD);
    issue(OP_LD, 0);
    issue(OP_AND);
    issue(OP_NOT);
    issue(OP_GT);
    issue(OP_RD, 0, 32'hFFFF_FFFF);
    issue(OP_EQ);
    issue(OP_OR);
    issue(OP_WR);
  endtask

  task automatic test_frames();
    issue(OP_LD, 5);
    issue(OP_LD, 32'hFFFF_FFFF);
    issue(OP_CAL, 100);
    issue(OP_LOC, 2);
    issue(OP_LD, 1);
    issue(OP_LD, 1);
    issue(OP_LDA);
    issue(OP_LDV);
    issue(OP_LD, DEPTH - 1);
    issue(OP_STV);
    issue(OP_RET, 0);
    issue(OP_LD, 0);
    issue(OP_CAL, 7);
    issue(OP_RET, 1);
  endtask

  task automatic test_branches();
    issue(OP_BR, 32'hFFFF_FFFF);
    issue(OP_LD, 1);
    issue(OP_BRF, 32'h0000_1234);
    issue(OP_LD, 0);
    issue(OP_BRF, 32'h0001_2345);
    issue(OP_RD, 0, 32'h0);
  endtask

  task automatic test_random(int unsigned n_words);
    int unsigned done_cnt;
    logic [7:0] op;
    logic [31:0] w;
    bit sent;
    done_cnt = 0;
    while (done_cnt < n_words) begin
      w = $urandom;
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4: begin op = OP_LD; w = pick_value(); end
        5: op = OP_RD;
        6: op = OP_ADD;
        7: op = OP_SUB;
        8: op = OP_MUL;
        9: op = OP_DIV;
        10: begin
          op = ($urandom_range(0, 1) == 1) ? OP_AND : OP_OR;
          if ($urandom_range(0, 1) == 1) op = ($urandom_range(0, 1) == 1) ? OP_EQ : OP_GT;
        end
        11: op = ($urandom_range(0, 1) == 1) ? OP_NOT : OP_WR;
        12: op = ($urandom_range(0, 1) == 1) ? OP_BRF : OP_BR;
        13, 14: op = OP_CAL;
        15: begin op = OP_RET; w = $urandom_range(0, 3); end
        16: begin
          op = OP_LOC;
          w = ($urandom_range(0, 31) == 0) ? 64 : $urandom_range(0, 4);
        end
        17: op = OP_STV;
        18: op = ($urandom_range(0, 1) == 1) ? OP_LDA : OP_LDV;
        default: op = ($urandom_range(0, 1) == 1) ? OP_WR : OP_NOP;
      endcase
      if (sp_q < 2000 && (op == OP_LD || op == OP_RD || op == OP_LOC)) op = OP_WR;
      send_word(op, w, $urandom, 1'b0, sent);
      if (sent) done_cnt++;
    end
  endtask

  task automatic test_stop();
    bit sent;
    case ($urandom_range(0, 2))
      0: send_word(OP_HALT, $urandom, $urandom, 1'b1, sent);
      1: send_word($urandom_range(OP_RD + 1, 255), $urandom, $urandom, 1'b1, sent);
      default: begin
        issue(OP_LD, 32'hFFFF_FFFF);
        send_word(OP_LDV, $urandom, $urandom, 1'b1, sent);
      end
    endcase
    repeat (24) send_word($urandom_range(0, 255), $urandom, $urandom, 1'b1, sent);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_q.size() == 0) begin
        $error("result word with no expectation: next_pc %0h", out_if.next_pc);
        fail_cnt++;
      end else begin
        exec_result_t e;
        e = pending_q.pop_front();
        if (out_if.next_pc !== e.next_pc) begin
          $error("next_pc: expected %0h, actual %0h", e.next_pc, out_if.next_pc);
          fail_cnt++;
        end
        if (out_if.write_valid !== e.write_valid) begin
          $error("write_valid: expected %0b, actual %0b", e.write_valid, out_if.write_valid);
          fail_cnt++;
        end
        if (out_if.write_value !== e.write_value) begin
          $error("write_value: expected %0h, actual %0h", e.write_value, out_if.write_value);
          fail_cnt++;
        end
        if (out_if.status !== e.status) begin
          $error("status: expected %0d, actual %0d", e.status, out_if.status);
          fail_cnt++;
        end
      end
    end
  end

  always begin
    int unsigned stall;
    @(posedge clk_i);
    if (rst_ni) begin
      stall = $urandom_range(0, 4);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      while (!(out_if.valid && out_if.ready)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    in_if.valid        = 1'b0;
    in_if.opcode       = '0;
    in_if.operand_word = '0;
    in_if.read_value   = '0;
    out_if.ready       = 1'b0;
    rst_ni             = 1'b0;
    fail_cnt           = 0;
    idle_cnt           = 0;
    sp_q               = DEPTH;
    fp_q               = DEPTH - 1;
    pc_q               = 0;
    halted             = 1'b0;
    halt_code          = STAT_RUN;
    foreach (stk_ok[i]) stk_ok[i] = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_arith();
    test_frames();
    test_branches();
    drain();
    test_random(1500);
    drain();
    test_stop();
    drain();
    repeat (100) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
